// ===== hw/rtl/htpl_pkg.sv =====
// Types and constants shared by the hash table probe lookup unit.
package htpl_pkg;

    localparam int CFG_W      = 11;
    localparam int KEY_W      = 32;
    localparam int REF_W      = 11;
    localparam int IDX_W      = 10;
    localparam int SLOT_OUT_W = 10;
    localparam int DIV_STEP   = 4;

    localparam int S_TDATA_W = 184;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 1;

    localparam logic [1:0] ACT_SLOT_WR  = 2'd0;
    localparam logic [1:0] ACT_BLOCK_WR = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;

    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] CAPACITY_RST    = 11'd1024;
    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 11'd0;

    typedef struct packed {
        logic [REF_W-1:0] blk_ref;
        logic [KEY_W-1:0] check2;
        logic [KEY_W-1:0] check1;
    } slot_entry_t;

    typedef struct packed {
        logic [KEY_W-1:0] start;
        logic [KEY_W-1:0] len;
    } block_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_CHK,
        ST_BLK,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/hash_table_probe_lookup_unit.sv =====
// Hash table probe lookup: slot and block memories with a linear probe sequencer.
// Slot and block writes are accepted in idle and give no result.
// Lookup: accept, key0 mod capacity (4 bits per cycle), read issue, then one slot memory
// read per probed slot (one per cycle), a block read if found and the output load;
// one item in flight at a time.
// Reset: aresetn synchronous active low; clears control and config (capacity 1024,
// block_count 0); table contents are undefined until written, no clearing pass.
module hash_table_probe_lookup_unit
    import htpl_pkg::*;
#(
    parameter int SLOT_DEPTH  = 1024,
    parameter int BLOCK_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // index, key0, key1, key2, block_ref, entry_len, entry_start, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [S_TUSER_W-1:0] s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // start_res, length, slot, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // found
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int BAW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

    // input field unpacking
    logic [IDX_W-1:0] in_index;
    logic [KEY_W-1:0] in_key0;
    logic [KEY_W-1:0] in_key1;
    logic [KEY_W-1:0] in_key2;
    logic [REF_W-1:0] in_block_ref;
    logic [KEY_W-1:0] in_entry_len;
    logic [KEY_W-1:0] in_entry_start;
    logic [1:0]       in_action;

    assign in_index       = s_tdata[9:0];
    assign in_key0        = s_tdata[41:10];
    assign in_key1        = s_tdata[73:42];
    assign in_key2        = s_tdata[105:74];
    assign in_block_ref   = s_tdata[116:106];
    assign in_entry_len   = s_tdata[148:117];
    assign in_entry_start = s_tdata[180:149];
    assign in_action      = s_tuser;

    // config registers
    logic [CFG_W-1:0] capacity_reg;
    logic [CFG_W-1:0] block_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg    <= CAPACITY_RST;
            block_count_reg <= BLOCK_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CAPACITY:    capacity_reg    <= cfg_wdata;
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] eff_cap;
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = CFG_W'(1);
        end else if (32'(capacity_reg) > 32'(SLOT_DEPTH)) begin
            eff_cap = CFG_W'(SLOT_DEPTH);
        end else begin
            eff_cap = capacity_reg;
        end
    end

    // control and datapath registers
    state_t state_reg, state_next;

    logic              s_accept;
    logic [CFG_W-1:0]  cap_reg;
    logic [KEY_W-1:0]  key1_reg;
    logic [KEY_W-1:0]  key2_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [2:0]        div_cnt_reg;
    logic [CFG_W-1:0]  rem_next;
    logic [CFG_W-1:0]  k_reg;
    logic [CFG_W-1:0]  probe_cnt_reg;

    logic              res_found_reg;
    logic [KEY_W-1:0]  res_start_reg;
    logic [KEY_W-1:0]  res_len_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;

    logic              m_tvalid_reg;
    logic              m_found_reg;
    logic [KEY_W-1:0]  m_start_reg;
    logic [KEY_W-1:0]  m_len_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;

    // memories
    slot_entry_t  slot_mem [SLOT_DEPTH];
    block_entry_t blk_mem  [BLOCK_DEPTH];
    slot_entry_t  slot_rd_reg;
    block_entry_t blk_rd_reg;

    logic           slot_rd_en;
    logic [SAW-1:0] slot_rd_addr;
    logic           blk_rd_en;
    logic [BAW-1:0] blk_rd_addr;
    logic           slot_wr_en;
    logic           blk_wr_en;

    assign s_accept   = s_tvalid && s_tready;
    assign slot_wr_en = s_accept && (in_action == ACT_SLOT_WR)
                        && (32'(in_index) < 32'(SLOT_DEPTH));
    assign blk_wr_en  = s_accept && (in_action == ACT_BLOCK_WR)
                        && (32'(in_index) < 32'(BLOCK_DEPTH));

    always_ff @(posedge aclk) begin
        if (slot_wr_en) begin
            slot_mem[SAW'(in_index)] <= '{blk_ref: in_block_ref, check2: in_key2,
                                          check1: in_key1};
        end
        if (slot_rd_en) begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (blk_wr_en) begin
            blk_mem[BAW'(in_index)] <= '{start: in_entry_start, len: in_entry_len};
        end
        if (blk_rd_en) begin
            blk_rd_reg <= blk_mem[blk_rd_addr];
        end
    end

    // probe evaluation
    logic            slot_empty;
    logic            slot_hit;
    logic [CFG_W:0]  k_plus;
    logic [CFG_W-1:0] k_inc;
    logic [CFG_W:0]  cnt_plus;
    logic            lap_done;
    logic            probe_more;

    assign slot_empty = (32'(slot_rd_reg.blk_ref) >= 32'(block_count_reg))
                        || (32'(slot_rd_reg.blk_ref) >= 32'(BLOCK_DEPTH));
    assign slot_hit   = (slot_rd_reg.check1 == key1_reg) && (slot_rd_reg.check2 == key2_reg);
    assign k_plus     = {1'b0, k_reg} + (CFG_W+1)'(1);
    assign k_inc      = (k_plus == {1'b0, cap_reg}) ? '0 : k_plus[CFG_W-1:0];
    assign cnt_plus   = {1'b0, probe_cnt_reg} + (CFG_W+1)'(1);
    assign lap_done   = (cnt_plus == {1'b0, cap_reg});
    assign probe_more = !slot_empty && !slot_hit && !lap_done;

    // remainder, DIV_STEP dividend bits per cycle
    always_comb begin
        logic [CFG_W:0] r;
        rem_next = k_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            r = {rem_next, dvd_reg[KEY_W-1-i]};
            if (r >= {1'b0, cap_reg}) begin
                r = r - {1'b0, cap_reg};
            end
            rem_next = r[CFG_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_action == ACT_LOOKUP)) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == 3'd7) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: state_next = ST_CHK;
            ST_CHK: begin
                if (slot_empty) begin
                    state_next = ST_OUT;
                end else if (slot_hit) begin
                    state_next = ST_BLK;
                end else if (lap_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_BLK:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready     = 1'b0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = SAW'(k_reg);
        blk_rd_en    = 1'b0;
        blk_rd_addr  = BAW'(slot_rd_reg.blk_ref);
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_PROBE: slot_rd_en = 1'b1;
            ST_CHK: begin
                slot_rd_en   = probe_more;
                slot_rd_addr = SAW'(k_inc);
                blk_rd_en    = !slot_empty && slot_hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cap_reg       <= eff_cap;
                key1_reg      <= in_key1;
                key2_reg      <= in_key2;
                dvd_reg       <= in_key0;
                div_cnt_reg   <= '0;
                k_reg         <= '0;
                probe_cnt_reg <= '0;
            end
            ST_DIV: begin
                k_reg       <= rem_next;
                dvd_reg     <= dvd_reg << DIV_STEP;
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            ST_CHK: begin
                res_found_reg <= 1'b0;
                res_start_reg <= '0;
                res_len_reg   <= '0;
                res_slot_reg  <= '0;
                if (probe_more) begin
                    k_reg         <= k_inc;
                    probe_cnt_reg <= cnt_plus[CFG_W-1:0];
                end
            end
            ST_BLK: begin
                res_found_reg <= 1'b1;
                res_start_reg <= blk_rd_reg.start;
                res_len_reg   <= blk_rd_reg.len;
                res_slot_reg  <= k_reg[SLOT_OUT_W-1:0];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_found_reg <= res_found_reg;
            m_start_reg <= res_start_reg;
            m_len_reg   <= res_len_reg;
            m_slot_reg  <= res_slot_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {6'd0, m_slot_reg, m_len_reg, m_start_reg};

    // checks
    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE || state_reg == ST_CHK)
        |-> (cap_reg != '0 && 32'(cap_reg) <= 32'(SLOT_DEPTH)))
        else $error("probe capacity out of range");

    a_k_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE || state_reg == ST_CHK) |-> (k_reg < cap_reg))
        else $error("probe slot beyond capacity");

    a_lap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK) |-> (probe_cnt_reg < cap_reg))
        else $error("probe ran past a full lap");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLK) |=> (state_reg == ST_OUT && !s_tready))
        else $error("block read not followed by result load");

endmodule

// ===== tb/sv/hash_table_probe_lookup_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the hash table probe lookup unit: directed and random probes.
module hash_table_probe_lookup_unit_test;
    import htpl_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int BLOCKS        = 1024;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 48;
    localparam int MAX_REPORTS   = 50;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic                  found;
        logic [KEY_W-1:0]      start_res;
        logic [KEY_W-1:0]      length;
        logic [SLOT_OUT_W-1:0] slot;
    } lookup_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_addr  = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // index, key0, key1, key2, block_ref, entry_len, entry_start, zero pad
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // action
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // start_res, length, slot, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    // found
    logic [M_TUSER_W-1:0] m_tuser;

    slot_entry_t      slot_mem      [SLOTS];
    block_entry_t     block_mem     [BLOCKS];
    bit               slot_written  [SLOTS];
    bit               block_written [BLOCKS];
    logic [CFG_W-1:0] cur_capacity    = CAPACITY_RST;
    logic [CFG_W-1:0] cur_block_count = BLOCK_COUNT_RST;

    lookup_result_t lookup_answers[$];

    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          mismatch_count  = 0;
    int          lookups_checked = 0;
    int          hits_checked    = 0;
    int          configs_used    = 0;
    int          stall_cycles    = 0;
    int unsigned win_base        = 0;
    int unsigned win_len         = 1;

    always #10 aclk = ~aclk;

    hash_table_probe_lookup_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic int unsigned live_slots();
        if (cur_capacity == 0) return 1;
        if (32'(cur_capacity) > SLOTS) return SLOTS;
        return 32'(cur_capacity);
    endfunction

    function automatic int unsigned live_blocks();
        if (32'(cur_block_count) > BLOCKS) return BLOCKS;
        return 32'(cur_block_count);
    endfunction

    // Walks the probe sequence; unsafe flags a read of a never-written entry.
    function automatic lookup_result_t probe_table(input logic [KEY_W-1:0] k0, k1, k2,
                                                   output bit unsafe);
        int unsigned    cap;
        int unsigned    pos;
        int unsigned    n;
        slot_entry_t    s;
        lookup_result_t r;
        cap = live_slots();
        pos = k0 % cap;
        r = '{found: 1'b0, start_res: '0, length: '0, slot: '0};
        unsafe = 1'b0;
        for (n = 0; n < cap; n++) begin
            if (!slot_written[IDX_W'(pos)]) begin
                unsafe = 1'b1;
                break;
            end
            s = slot_mem[IDX_W'(pos)];
            if (32'(s.blk_ref) >= live_blocks()) break;
            if (s.check1 == k1 && s.check2 == k2) begin
                if (!block_written[IDX_W'(s.blk_ref)]) unsafe = 1'b1;
                r.found     = 1'b1;
                r.start_res = block_mem[IDX_W'(s.blk_ref)].start;
                r.length    = block_mem[IDX_W'(s.blk_ref)].len;
                r.slot      = pos[SLOT_OUT_W-1:0];
                break;
            end
            pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
        return r;
    endfunction

    // key0 that lands on pos under the current capacity, upper bits random
    function automatic logic [KEY_W-1:0] key0_at(input int unsigned pos);
        longint unsigned cap;
        longint unsigned q;
        cap = 64'(live_slots());
        q = 64'($urandom_range(0, 32'((64'hFFFF_FFFF - 64'(pos)) / cap)));
        return KEY_W'(q * cap + 64'(pos));
    endfunction

    function automatic int unsigned window_slot();
        return (win_base + $urandom_range(0, win_len - 1)) % live_slots();
    endfunction

    task automatic set_mode(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 6;
                recv_stall_pct = 45;
            end
            1: begin
                send_idle_pct  = 45;
                recv_stall_pct = 6;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                             input logic [KEY_W-1:0] k0, k1, k2,
                             input logic [REF_W-1:0] bref,
                             input logic [KEY_W-1:0] elen, estart);
        bit unsafe;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'({estart, elen, bref, k2, k1, k0, idx});
        do @(posedge aclk); while (!s_tready);
        case (act)
            ACT_SLOT_WR: begin
                slot_mem[idx].check1  = k1;
                slot_mem[idx].check2  = k2;
                slot_mem[idx].blk_ref = bref;
                slot_written[idx]     = 1'b1;
            end
            ACT_BLOCK_WR: begin
                block_mem[idx].len   = elen;
                block_mem[idx].start = estart;
                block_written[idx]   = 1'b1;
            end
            ACT_LOOKUP: lookup_answers.push_back(probe_table(k0, k1, k2, unsafe));
            default: ;
        endcase
    endtask

    task automatic write_slot(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] c1, c2,
                              input logic [REF_W-1:0] bref);
        send_item(ACT_SLOT_WR, idx, $urandom, c1, c2, bref, $urandom, $urandom);
    endtask

    task automatic write_block(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] len, start);
        send_item(ACT_BLOCK_WR, idx, $urandom, $urandom, $urandom, REF_W'($urandom), len, start);
    endtask

    task automatic send_lookup(input logic [KEY_W-1:0] k0, k1, k2);
        send_item(ACT_LOOKUP, IDX_W'($urandom), k0, k1, k2, REF_W'($urandom),
                  $urandom, $urandom);
    endtask

    task automatic send_unused();
        send_item(ACT_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom,
                  REF_W'($urandom), $urandom, $urandom);
    endtask

    // Block is idle once every lookup has answered and the last write has retired.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (lookup_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] capacity, blocks);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_CAPACITY;
        cfg_wdata <= capacity;
        @(posedge aclk);
        cfg_addr  <= REG_BLOCK_COUNT;
        cfg_wdata <= blocks;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_capacity    = capacity;
        cur_block_count = blocks;
        configs_used++;
    endtask

    // Occupied slots get their block written first; empty ones sit at or past the limit.
    task automatic fill_slot(input logic [IDX_W-1:0] idx);
        logic [KEY_W-1:0] c1;
        logic [KEY_W-1:0] c2;
        logic [REF_W-1:0] bref;
        int unsigned      live;
        int unsigned      donor;
        live  = live_blocks();
        c1    = $urandom;
        c2    = $urandom;
        donor = window_slot();
        if ($urandom_range(0, 99) < 20 && slot_written[IDX_W'(donor)]) begin
            c1 = slot_mem[IDX_W'(donor)].check1;
            c2 = slot_mem[IDX_W'(donor)].check2;
        end
        if (live > 0 && $urandom_range(0, 99) < 65) begin
            bref = REF_W'($urandom_range(0, live - 1));
            if (!block_written[bref[IDX_W-1:0]])
                write_block(bref[IDX_W-1:0], $urandom, $urandom);
        end else begin
            case ($urandom_range(0, 2))
                0: bref = REF_W'(live);
                1: bref = REF_W'($urandom_range(live, (1 << REF_W) - 1));
                default: bref = REF_W'($urandom_range(BLOCKS, (1 << REF_W) - 1));
            endcase
        end
        write_slot(idx, c1, c2, bref);
    endtask

    task automatic random_lookup();
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] k1;
        logic [KEY_W-1:0] k2;
        int unsigned      src;
        int unsigned      pick;
        int unsigned      tries;
        bit               unsafe;
        src  = window_slot();
        pick = $urandom_range(0, 99);
        k1   = $urandom;
        k2   = $urandom;
        if (pick < 60) begin
            k1 = slot_mem[IDX_W'(src)].check1;
            k2 = slot_mem[IDX_W'(src)].check2;
        end else if (pick < 70) begin
            k1 = slot_mem[IDX_W'(src)].check1;
        end
        for (tries = 0; tries < 16; tries++) begin
            k0 = key0_at(window_slot());
            void'(probe_table(k0, k1, k2, unsafe));
            if (!unsafe) begin
                send_lookup(k0, k1, k2);
                break;
            end
        end
    endtask

    task automatic test_reset_state();
        logic [KEY_W-1:0] c1;
        logic [KEY_W-1:0] c2;
        c1 = $urandom;
        c2 = $urandom;
        // block_count resets to zero, so every slot reads as empty
        write_slot(5, c1, c2, 0);
        send_lookup(key0_at(5), c1, c2);
    endtask

    task automatic test_directed_probes();
        logic [KEY_W-1:0] ka1, ka2, kb1, kb2, kc1, kc2;
        ka1 = $urandom;
        ka2 = $urandom;
        kb1 = $urandom;
        kb2 = $urandom;
        kc1 = $urandom;
        kc2 = $urandom;
        settle();
        set_config(4, 3);
        write_block(0, '1, '0);
        write_block(1, '0, '1);
        write_block(2, $urandom, $urandom);
        write_slot(0, '0, '0, 0);
        write_slot(1, ka1, ka2, 2);
        write_slot(2, kb1, kb2, '1);
        write_slot(3, '1, '1, 1);
        send_lookup('0, '0, '0);
        send_lookup('1, '0, '0);
        send_lookup(key0_at(3), '1, '1);
        send_lookup(key0_at(1), kb1, kb2);
        send_lookup(key0_at(3), ka1, kb2);
        send_unused();

        settle();
        set_config(2, 3);
        send_lookup($urandom, kb1, kb2);

        // zero capacity probes a single slot
        settle();
        set_config(0, '1);
        send_lookup($urandom, '0, '0);
        send_lookup($urandom, ka1, ka2);

        // capacity saturates at the table depth; slot 1 now references block_count itself
        settle();
        set_config(1025, 2);
        write_slot(1023, kc1, kc2, 1);
        send_lookup(key0_at(1023), kc1, kc2);
        send_lookup(key0_at(1023), '0, '0);
        send_lookup(key0_at(1), ka1, ka2);
    endtask

    task automatic test_random_tables();
        int unsigned cap_list [PHASES] = '{3, 1, 2047, 17, 0, 1024, 40, 2, 1025, 64, 9, 300};
        int unsigned blk_list [PHASES] = '{5, 1, 40, 2047, 12, 0, 1024, 3, 30, 200, 1, 60};
        int unsigned cap;
        int unsigned ph;
        int unsigned i;
        int unsigned n;
        int unsigned pick;
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            set_mode(ph / 4);
            set_config(CFG_W'(cap_list[ph]), CFG_W'(blk_list[ph]));
            cap      = live_slots();
            win_len  = (cap <= 64) ? cap : 24;
            win_base = (cap <= 64) ? 0 : $urandom_range(0, cap - 1);
            for (i = 0; i < win_len; i++) fill_slot(IDX_W'((win_base + i) % cap));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    random_lookup();
                end else if (pick < 82) begin
                    fill_slot(IDX_W'(($urandom_range(0, 3) == 0) ? $urandom : window_slot()));
                end else if (pick < 96) begin
                    write_block(IDX_W'($urandom), $urandom, $urandom);
                end else begin
                    send_unused();
                end
            end
        end
    endtask

    task automatic check_field(input string field, input logic [KEY_W-1:0] want, got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        lookup_result_t want;
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (lookup_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $error("result transfer with no lookup pending, found=%0b", m_tuser[0]);
            end else begin
                want = lookup_answers.pop_front();
                lookups_checked++;
                if (want.found) hits_checked++;
                check_field("found", KEY_W'(want.found), KEY_W'(m_tuser[0]));
                check_field("start_res", want.start_res, m_tdata[31:0]);
                check_field("length", want.length, m_tdata[63:32]);
                check_field("slot", KEY_W'(want.slot), KEY_W'(m_tdata[73:64]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        set_mode(0);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_directed_probes();
        test_random_tables();
        settle();
        $display("Checked %0d lookups (%0d hits) over %0d register settings and three idle mixes.",
                 lookups_checked, hits_checked, configs_used);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/htpl_pkg.sv
hw/rtl/hash_table_probe_lookup_unit.sv
tb/sv/hash_table_probe_lookup_unit_test.sv
